// ===== rtl/serial_boot_loader_fsm_core_defines.svh =====
// Assertion macros for the serial boot loader core.
// Depends on nothing; included by the top level only.
`ifndef SERIAL_BOOT_LOADER_FSM_CORE_DEFINES_SVH
`define SERIAL_BOOT_LOADER_FSM_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SBL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbl: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define SBL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbl: next-cycle check failed");

`endif

// ===== rtl/sbl_pkg.sv =====
// Shared types, character codes and result expansion for the boot loader.
// No dependencies; used by the core, front end, queue, sequencer and bench through scoped names.
package sbl_pkg;

    // Characters sent and recognized
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_O_UP  = 8'h4F;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_EXCL  = 8'h21;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_O_LO  = 8'h6F;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_QUEST = 8'h3F;

    localparam logic [31:0] LOAD_BASE_RESET = 32'h0000_0800;
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_TX    = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_START = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        CMD_BOOT     = 3'd0,
        CMD_OK       = 3'd1,
        CMD_WRITE    = 3'd2,
        CMD_WRITE_GO = 3'd3,
        CMD_GO       = 3'd4
    } cmd_op_t;

    // One classified item, as queued between front and back
    typedef struct packed {
        cmd_op_t     op;
        logic [31:0] addr;
        logic [31:0] data;
    } cmd_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  tx_byte;
        logic [31:0] mem_addr;
        logic [31:0] mem_data;
        logic        last;
    } result_t;

    function automatic logic [7:0] boot_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CH_B;
            3'd1:    c = CH_O_LO;
            3'd2:    c = CH_O_LO;
            3'd3:    c = CH_T;
            default: c = CH_QUEST;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] go_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = CH_G;
            2'd1:    c = CH_O_LO;
            default: c = CH_EXCL;
        endcase
        return c;
    endfunction

    function automatic result_t tx_result(input logic [7:0] c, input logic last);
        result_t r;
        r.kind     = KIND_TX;
        r.tx_byte  = c;
        r.mem_addr = '0;
        r.mem_data = '0;
        r.last     = last;
        return r;
    endfunction

    // Expand one step of a queued command into a result item
    function automatic result_t expand(input cmd_t cmd, input logic [2:0] step,
                                       input logic [31:0] base);
        result_t r;
        logic [1:0] gidx;
        r    = tx_result(8'h00, 1'b0);
        gidx = 2'd0;
        case (cmd.op)
            CMD_BOOT:
            begin
                r = tx_result(boot_char(step), step == 3'd4);
            end
            CMD_OK:
            begin
                r = tx_result((step == 3'd0) ? CH_O_UP : CH_K, step == 3'd1);
            end
            CMD_WRITE, CMD_WRITE_GO:
            begin
                if (step == 3'd0)
                begin
                    r.kind     = KIND_WRITE;
                    r.mem_addr = cmd.addr;
                    r.mem_data = cmd.data;
                    r.last     = (cmd.op == CMD_WRITE);
                end
                else if (step == 3'd4)
                begin
                    r.kind     = KIND_START;
                    r.mem_addr = base;
                    r.last     = 1'b1;
                end
                else
                begin
                    gidx = step[1:0] - 2'd1;
                    r    = tx_result(go_char(gidx), 1'b0);
                end
            end
            CMD_GO:
            begin
                if (step == 3'd3)
                begin
                    r.kind     = KIND_START;
                    r.mem_addr = base;
                    r.last     = 1'b1;
                end
                else
                begin
                    r = tx_result(go_char(step[1:0]), 1'b0);
                end
            end
            default:
            begin
                r = tx_result(8'h00, 1'b1);
            end
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/sbl_if.sv =====
// Valid/ready channel interfaces: input items, result items, config writes.
// Depends on nothing.
interface sbl_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;
    modport source (output valid, output op, output rx_byte, input ready);
    modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface sbl_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [31:0] mem_addr;
    logic [31:0] mem_data;
    logic        last;
    modport source (output valid, output kind, output tx_byte, output mem_addr,
                    output mem_data, output last, input ready);
    modport sink (input valid, input kind, input tx_byte, input mem_addr,
                  input mem_data, input last, output ready);
endinterface

interface sbl_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/serial_boot_loader_fsm_core.sv =====
// An accepted item is written into a queue slot; its first result is then registered in the output register.
// Items are taken one per cycle while the queue is not full; the output register sends
// one result per cycle while results_out.ready is high; the 4-deep queue absorbs bursts.
// Items that cause no result never occupy the queue or the output stage.
// Reset (rst_n low, asynchronous): phase to wait-for-Y, counters cleared,
// load_base to 0x800, queue and output register empty.
`include "serial_boot_loader_fsm_core_defines.svh"

module serial_boot_loader_fsm_core (
    input  logic       clk,
    input  logic       rst_n,
    sbl_in_if.sink     items_in,
    sbl_out_if.source  results_out,
    sbl_cfg_if.sink    cfg
);

    logic [31:0]   load_base_reg;
    logic [31:0]   load_base_next;
    logic          push;
    logic          pop;
    logic          q_empty;
    logic          q_full;
    sbl_pkg::cmd_t push_cmd;
    sbl_pkg::cmd_t head;

    // Take configuration writes at any time
    assign cfg.ready      = 1'b1;
    assign load_base_next = (cfg.valid && cfg.ready) ? cfg.data : load_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            load_base_reg <= sbl_pkg::LOAD_BASE_RESET;
        else
            load_base_reg <= load_base_next;
    end

    sbl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .items_in  (items_in),
        .q_full    (q_full),
        .load_base (load_base_reg),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    sbl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    sbl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (q_empty),
        .load_base   (load_base_reg),
        .pop         (pop),
        .results_out (results_out)
    );

    // Checks
    `SBL_ASSERT_IMPLY(a_push_on_accept, clk, rst_n, push, items_in.valid && items_in.ready)
    `SBL_ASSERT_IMPLY(a_start_is_last, clk, rst_n, results_out.valid && (results_out.kind == sbl_pkg::KIND_START), results_out.last)
    `SBL_ASSERT_IMPLY(a_start_at_base, clk, rst_n, results_out.valid && (results_out.kind == sbl_pkg::KIND_START), results_out.mem_addr == load_base_reg)
    `SBL_ASSERT_NEXT(a_pop_frees_slot, clk, rst_n, q_full && pop && !push, !q_full)

endmodule

// ===== rtl/sbl_front.sv =====
// Front end: accepts input items, runs the loader phases, classifies commands.
// Depends on sbl_pkg and sbl_if.
module sbl_front (
    input  logic           clk,
    input  logic           rst_n,
    sbl_in_if.sink         items_in,
    input  logic           q_full,
    input  logic [31:0]    load_base,
    output logic           push,
    output sbl_pkg::cmd_t  push_cmd
);

    sbl_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  pos_reg, pos_next;
    logic [31:0] len_reg, len_next;
    logic [23:0] word_reg, word_next;
    logic [31:0] waddr_reg, waddr_next;
    logic [32:0] end_reg, end_next;

    logic        accept;
    logic        is_byte;
    logic [31:0] len_new;
    logic [32:0] addr_plus4;
    logic        load_done;

    assign items_in.ready = !q_full;
    assign accept  = items_in.valid && items_in.ready;
    assign is_byte = accept && items_in.op;

    assign len_new    = {len_reg[23:0], items_in.rx_byte};
    assign addr_plus4 = {1'b0, waddr_reg} + 33'd4;
    assign load_done  = (addr_plus4 >= end_reg) || addr_plus4[32];

    // Advance the phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            sbl_pkg::PH_WAIT:
            begin
                if (is_byte && (items_in.rx_byte == sbl_pkg::CH_Y))
                    phase_next = sbl_pkg::PH_LEN;
            end
            sbl_pkg::PH_LEN:
            begin
                if (is_byte && (pos_reg == 2'd3))
                    phase_next = (len_new == 32'd0) ? sbl_pkg::PH_DONE : sbl_pkg::PH_DATA;
            end
            sbl_pkg::PH_DATA:
            begin
                if (is_byte && (pos_reg == 2'd3) && load_done)
                    phase_next = sbl_pkg::PH_DONE;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Update counters and accumulators, classify the item
    always_comb
    begin
        pos_next   = pos_reg;
        len_next   = len_reg;
        word_next  = word_reg;
        waddr_next = waddr_reg;
        end_next   = end_reg;
        push       = 1'b0;
        push_cmd.op   = sbl_pkg::CMD_BOOT;
        push_cmd.addr = waddr_reg;
        push_cmd.data = {items_in.rx_byte, word_reg};
        if (accept && !items_in.op)
        begin
            push = 1'b1;
        end
        else if (is_byte)
        begin
            case (phase_reg)
                sbl_pkg::PH_WAIT:
                begin
                    if (items_in.rx_byte == sbl_pkg::CH_Y)
                    begin
                        push        = 1'b1;
                        push_cmd.op = sbl_pkg::CMD_OK;
                        pos_next    = 2'd0;
                        len_next    = 32'd0;
                    end
                end
                sbl_pkg::PH_LEN:
                begin
                    len_next = len_new;
                    pos_next = pos_reg + 2'd1;
                    if (pos_reg == 2'd3)
                    begin
                        end_next   = {1'b0, load_base} + {1'b0, len_new};
                        waddr_next = load_base;
                        word_next  = 24'd0;
                        if (len_new == 32'd0)
                        begin
                            push        = 1'b1;
                            push_cmd.op = sbl_pkg::CMD_GO;
                        end
                    end
                end
                sbl_pkg::PH_DATA:
                begin
                    pos_next = pos_reg + 2'd1;
                    case (pos_reg)
                        2'd0:    word_next = {word_reg[23:8], items_in.rx_byte};
                        2'd1:    word_next = {word_reg[23:16], items_in.rx_byte,
                                              word_reg[7:0]};
                        2'd2:    word_next = {items_in.rx_byte, word_reg[15:0]};
                        default:
                        begin
                            word_next   = 24'd0;
                            push        = 1'b1;
                            push_cmd.op = load_done ? sbl_pkg::CMD_WRITE_GO
                                                    : sbl_pkg::CMD_WRITE;
                            if (!load_done)
                                waddr_next = addr_plus4[31:0];
                        end
                    endcase
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    // Hold loader state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sbl_pkg::PH_WAIT;
            pos_reg   <= 2'd0;
            len_reg   <= 32'd0;
            word_reg  <= 24'd0;
            waddr_reg <= 32'd0;
            end_reg   <= 33'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            word_reg  <= word_next;
            waddr_reg <= waddr_next;
            end_reg   <= end_next;
        end
    end

endmodule

// ===== rtl/sbl_queue.sv =====
// Short command queue between the front end and the result sequencer.
// Depends on sbl_pkg.
module sbl_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sbl_pkg::cmd_t  push_cmd,
    input  logic           pop,
    output sbl_pkg::cmd_t  head,
    output logic           empty,
    output logic           full
);

    sbl_pkg::cmd_t slot_reg [sbl_pkg::QDEPTH];
    logic [sbl_pkg::QPTR_W-1:0] wr_reg, wr_next;
    logic [sbl_pkg::QPTR_W-1:0] rd_reg, rd_next;
    logic [sbl_pkg::QPTR_W:0]   cnt_reg, cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (sbl_pkg::QPTR_W + 1)'(sbl_pkg::QDEPTH));
    assign head  = slot_reg[rd_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_cmd;
    end

endmodule

// ===== rtl/sbl_back.sv =====
// Result sequencer: expands queued commands, a result per cycle while ready.
// Depends on sbl_pkg and sbl_if.
module sbl_back (
    input  logic           clk,
    input  logic           rst_n,
    input  sbl_pkg::cmd_t  head,
    input  logic           empty,
    input  logic [31:0]    load_base,
    output logic           pop,
    sbl_out_if.source      results_out
);

    logic              out_valid_reg, out_valid_next;
    sbl_pkg::result_t  out_res_reg, out_res_next;
    logic [2:0]        step_reg, step_next;
    logic              load;
    sbl_pkg::result_t  res;

    assign load = !empty && (!out_valid_reg || results_out.ready);
    assign res  = sbl_pkg::expand(head, step_reg, load_base);
    assign pop  = load && res.last;

    // Step through the head command and refill the output register
    always_comb
    begin
        step_next      = step_reg;
        out_res_next   = out_res_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_res_next   = res;
            out_valid_next = 1'b1;
            step_next      = res.last ? 3'd0 : step_reg + 3'd1;
        end
        else if (results_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= 3'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign results_out.valid    = out_valid_reg;
    assign results_out.kind     = out_res_reg.kind;
    assign results_out.tx_byte  = out_res_reg.tx_byte;
    assign results_out.mem_addr = out_res_reg.mem_addr;
    assign results_out.mem_data = out_res_reg.mem_data;
    assign results_out.last     = out_res_reg.last;

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for serial_boot_loader_fsm_core: prompt, handshake, length and word load.
// Depends on sbl_pkg, the sbl_*_if channel interfaces and the core itself.
// A built-in predictor checks every result item in order, under random idling on both sides.
module tb;

    localparam logic        OP_PROMPT    = 1'b0;
    localparam logic        OP_BYTE      = 1'b1;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned HOLD_CYCLES  = 120;
    localparam int unsigned CYCLE_LIMIT  = 500000;

    typedef enum logic [1:0] {
        PLAN_PLAIN,
        PLAN_TOP,
        PLAN_EMPTY
    } load_plan_t;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } serial_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sbl_in_if  items_if();
    sbl_out_if results_if();
    sbl_cfg_if cfg_if();

    serial_boot_loader_fsm_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .items_in    (items_if),
        .results_out (results_if),
        .cfg         (cfg_if)
    );

    // Predictor state, a shadow of the loader
    sbl_pkg::phase_t load_phase = sbl_pkg::PH_WAIT;
    logic [1:0]  byte_pos = 2'd0;
    logic [31:0] len_acc = 32'd0;
    logic [23:0] word_acc = 24'd0;
    logic [31:0] wr_addr = 32'd0;
    logic [32:0] end_addr = 33'd0;
    logic [31:0] base_shadow = sbl_pkg::LOAD_BASE_RESET;

    sbl_pkg::result_t expected_results[$];
    sbl_pkg::result_t held;
    logic        held_valid = 1'b0;

    serial_item_t pending_items[$];
    logic         item_taken = 1'b0;
    int unsigned  gap_left = 0;
    int unsigned  stall_left = 0;
    int unsigned  calm_left[2];
    int unsigned  hold_left = 0;
    logic         hold_request = 1'b0;

    int unsigned mismatches = 0;
    int unsigned items_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned stores_seen = 0;
    int unsigned base_writes = 0;
    int unsigned cycle_count = 0;

    // Clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: run timed out with %0d results outstanding", $time,
                     expected_results.size());
            $display("serial_boot_loader_fsm_core: mismatch");
            $finish;
        end
    end

    // Pick an idle length: mostly none, some short, a few long, with calm stretches
    function automatic int unsigned idle_len(input int side);
        int unsigned roll;
        if (calm_left[side] != 0)
        begin
            calm_left[side] = calm_left[side] - 1;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll == 0)
        begin
            calm_left[side] = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Queue one result; the previous one is known not to be the last
    task automatic emit(input sbl_pkg::kind_t k, input logic [7:0] c, input logic [31:0] a,
                        input logic [31:0] d);
        if (held_valid)
            expected_results.push_back(held);
        held.kind     = k;
        held.tx_byte  = c;
        held.mem_addr = a;
        held.mem_data = d;
        held.last     = 1'b0;
        held_valid    = 1'b1;
    endtask

    task automatic emit_char(input logic [7:0] c);
        emit(sbl_pkg::KIND_TX, c, 32'd0, 32'd0);
    endtask

    // Send "Go!" and the start result, then stop loading
    task automatic finish_load();
        emit_char(sbl_pkg::CH_G);
        emit_char(sbl_pkg::CH_O_LO);
        emit_char(sbl_pkg::CH_EXCL);
        emit(sbl_pkg::KIND_START, 8'h00, base_shadow, 32'd0);
        load_phase = sbl_pkg::PH_DONE;
    endtask

    // Advance the shadow loader by one accepted item and queue its results
    task automatic predict_item(input logic op_bit, input logic [7:0] b);
        logic [32:0] next_addr;
        held_valid = 1'b0;
        if (op_bit == OP_PROMPT)
        begin
            emit_char(sbl_pkg::CH_B);
            emit_char(sbl_pkg::CH_O_LO);
            emit_char(sbl_pkg::CH_O_LO);
            emit_char(sbl_pkg::CH_T);
            emit_char(sbl_pkg::CH_QUEST);
        end
        else
        begin
            case (load_phase)
                sbl_pkg::PH_WAIT:
                begin
                    if (b == sbl_pkg::CH_Y)
                    begin
                        emit_char(sbl_pkg::CH_O_UP);
                        emit_char(sbl_pkg::CH_K);
                        load_phase = sbl_pkg::PH_LEN;
                        byte_pos   = 2'd0;
                        len_acc    = 32'd0;
                    end
                end
                sbl_pkg::PH_LEN:
                begin
                    len_acc  = {len_acc[23:0], b};
                    byte_pos = byte_pos + 2'd1;
                    if (byte_pos == 2'd0)
                    begin
                        end_addr = {1'b0, base_shadow} + {1'b0, len_acc};
                        wr_addr  = base_shadow;
                        word_acc = 24'd0;
                        if (len_acc == 32'd0)
                            finish_load();
                        else
                            load_phase = sbl_pkg::PH_DATA;
                    end
                end
                sbl_pkg::PH_DATA:
                begin
                    if (byte_pos != 2'd3)
                    begin
                        word_acc[8*byte_pos +: 8] = b;
                        byte_pos = byte_pos + 2'd1;
                    end
                    else
                    begin
                        emit(sbl_pkg::KIND_WRITE, 8'h00, wr_addr, {b, word_acc});
                        byte_pos  = 2'd0;
                        word_acc  = 24'd0;
                        next_addr = {1'b0, wr_addr} + 33'd4;
                        if (next_addr >= end_addr || next_addr[32])
                            finish_load();
                        else
                            wr_addr = next_addr[31:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (held_valid)
        begin
            held.last = 1'b1;
            expected_results.push_back(held);
            held_valid = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatches = mismatches + 1;
        end
    endtask

    // Item driver: offer the next pending item, with random gaps
    always @(negedge clk)
    begin
        serial_item_t next_item;
        if (!rst_n)
            items_if.valid <= 1'b0;
        else if (!items_if.valid || item_taken)
        begin
            if (gap_left != 0)
            begin
                gap_left = gap_left - 1;
                items_if.valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                next_item = pending_items.pop_front();
                items_if.op      <= next_item.op;
                items_if.rx_byte <= next_item.rx_byte;
                items_if.valid   <= 1'b1;
                gap_left = idle_len(0);
            end
            else
                items_if.valid <= 1'b0;
        end
    end

    // Long receiver hold-off, counted on its own
    always @(posedge clk)
    begin
        if (hold_request)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Result ready: drop it for the long hold or for random stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            results_if.ready <= 1'b0;
        else if (hold_left != 0)
            results_if.ready <= 1'b0;
        else if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            results_if.ready <= 1'b0;
        end
        else
        begin
            results_if.ready <= 1'b1;
            stall_left = idle_len(1);
        end
    end

    // Monitor: check results, predict accepted items, track base writes
    always @(posedge clk)
    begin
        sbl_pkg::result_t want;
        item_taken <= items_if.valid && items_if.ready;
        if (rst_n)
        begin
            if (results_if.valid && results_if.ready)
            begin
                results_checked = results_checked + 1;
                if (results_if.kind == sbl_pkg::KIND_WRITE)
                    stores_seen = stores_seen + 1;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result expected none actual kind %0d tx %h addr %h data %h last %b",
                             $time, results_if.kind, results_if.tx_byte, results_if.mem_addr,
                             results_if.mem_data, results_if.last);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("kind", 32'(want.kind), 32'(results_if.kind));
                    check_field("tx_byte", 32'(want.tx_byte), 32'(results_if.tx_byte));
                    check_field("mem_addr", want.mem_addr, results_if.mem_addr);
                    check_field("mem_data", want.mem_data, results_if.mem_data);
                    check_field("last", 32'(want.last), 32'(results_if.last));
                end
            end
            if (items_if.valid && items_if.ready)
            begin
                items_accepted = items_accepted + 1;
                predict_item(items_if.op, items_if.rx_byte);
            end
            if (cfg_if.valid && cfg_if.ready)
            begin
                base_shadow = cfg_if.data;
                base_writes = base_writes + 1;
            end
        end
    end

    task automatic send(input logic op_bit, input logic [7:0] b);
        serial_item_t it;
        it.op      = op_bit;
        it.rx_byte = b;
        pending_items.push_back(it);
    endtask

    task automatic send_prompt();
        send(OP_PROMPT, 8'($urandom_range(0, 255)));
    endtask

    // Hold until every pending item is taken and every expected result has come
    task automatic settle();
        @(posedge clk);
        while (pending_items.size() != 0 || items_if.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_base(input logic [31:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic hold_results();
        @(negedge clk);
        hold_request = 1'b1;
        @(negedge clk);
        hold_request = 1'b0;
    endtask

    // Stimulus
    initial
    begin
        load_plan_t      plan;
        int unsigned     roll;
        logic [31:0]     plan_base;
        logic [31:0]     plan_count;
        longint unsigned word_total;
        longint unsigned room_words;
        int unsigned     k;
        int unsigned     tail_items;
        logic [7:0]      b;
        items_if.valid   = 1'b0;
        items_if.op      = OP_PROMPT;
        items_if.rx_byte = 8'h00;
        results_if.ready = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.data      = 32'd0;
        calm_left[0]     = 0;
        calm_left[1]     = 0;

        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Choose the one load this run performs
        roll = $urandom_range(0, 7);
        if (roll < 5)
        begin
            plan       = PLAN_PLAIN;
            plan_base  = $urandom_range(0, 32'hF000_0000);
            if ($urandom_range(0, 3) != 0)
                plan_base[1:0] = 2'b00;
            plan_count = $urandom_range(200, 290);
        end
        else if (roll < 7)
        begin
            plan       = PLAN_TOP;
            k          = $urandom_range(50, 70);
            plan_base  = 32'(64'h1_0000_0000 - 4 * k - $urandom_range(0, 3));
            plan_count = $urandom | 32'h8000_0000;
        end
        else
        begin
            plan       = PLAN_EMPTY;
            plan_base  = $urandom;
            plan_count = 32'd0;
        end
        word_total = (longint'(plan_count) + 3) / 4;
        room_words = (64'h1_0000_0000 - longint'(plan_base) + 3) / 4;
        if (room_words < word_total)
            word_total = room_words;

        write_base(32'hFFFF_FFFF);

        // Wait phase: prompts still answer and several near misses of 'Y' are ignored
        send_prompt();
        send(OP_BYTE, 8'h00);
        send(OP_BYTE, 8'hFF);
        send(OP_BYTE, sbl_pkg::CH_Y - 8'd1);
        send(OP_BYTE, sbl_pkg::CH_Y + 8'd1);
        send(OP_BYTE, sbl_pkg::CH_Y | 8'h20);
        send(OP_BYTE, sbl_pkg::CH_Y ^ 8'h80);
        send_prompt();
        repeat (10)
        begin
            b = 8'($urandom_range(0, 255));
            send(OP_BYTE, (b == sbl_pkg::CH_Y) ? 8'h00 : b);
        end
        settle();
        write_base(32'd0);

        // Length phase, big-endian, with the base changed before its last bytes
        send(OP_BYTE, sbl_pkg::CH_Y);
        send(OP_BYTE, plan_count[31:24]);
        send_prompt();
        send(OP_BYTE, plan_count[23:16]);
        settle();
        write_base(plan_base);
        send(OP_BYTE, plan_count[15:8]);
        send(OP_BYTE, plan_count[7:0]);

        // Data phase: an all-zero word, an all-ones word, then random words
        for (longint unsigned i = 0; i < 4 * word_total; i++)
        begin
            if (i == 4 * (word_total / 2) + 1)
            begin
                settle();
                write_base($urandom);
            end
            if ($urandom_range(0, 19) == 0)
                send_prompt();
            if (i < 4)
                b = 8'h00;
            else if (i < 8)
                b = 8'hFF;
            else
                b = 8'($urandom_range(0, 255));
            send(OP_BYTE, b);
        end

        // Done phase: bytes are ignored, prompts still answer
        send(OP_BYTE, sbl_pkg::CH_Y);
        send(OP_BYTE, 8'h00);
        send(OP_BYTE, 8'hFF);
        send_prompt();
        settle();

        // Stall the receiver while prompts keep coming
        hold_results();
        repeat (6)
            send_prompt();
        repeat (10)
            send(OP_BYTE, 8'($urandom_range(0, 255)));
        settle();
        write_base(32'hFFFF_FFFC);

        tail_items = (plan == PLAN_EMPTY) ? 250 : 30;
        repeat (tail_items)
        begin
            if ($urandom_range(0, 3) == 0)
                send_prompt();
            else
                send(OP_BYTE, 8'($urandom_range(0, 255)));
        end
        settle();

        $display("load plan %0d: base %h, byte count %h, %0d words", plan, plan_base,
                 plan_count, word_total);
        $display("%0d items in, %0d results checked, %0d memory writes, %0d base writes",
                 items_accepted, results_checked, stores_seen, base_writes);
        if (mismatches == 0)
            $display("serial_boot_loader_fsm_core: match");
        else
            $display("serial_boot_loader_fsm_core: mismatch");
        $finish;
    end
endmodule
